// File: design/binary_heap_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Binary heap priority queue assertion macros
// Clocked assertion wrappers used by the heap queue RTL.
// ----------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BHPQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BHPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/bhpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary heap priority queue package
// Entry layout, status and operation codes, and the ordering function.
// ----------------------------------------------------------------------------
package bhpq_pkg;

   localparam int HEAP_DEPTH_DEFAULT = 64;
   localparam int KEY_W              = 16;
   localparam int PAY_W              = 16;
   localparam int OCC_W              = 7;

   localparam logic       KIND_PUSH    = 1'b0;
   localparam logic       KIND_POP     = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } entry_type;

   // True when key a leaves the heap strictly before key b.
   function automatic logic comes_before(input logic             max_first,
                                         input logic [KEY_W-1:0] a,
                                         input logic [KEY_W-1:0] b);
      comes_before = max_first ? (a > b) : (a < b);
   endfunction

endpackage
`default_nettype wire

// File: design/binary_heap_priority_queue.sv
// A refused request goes straight to the done state; a push reads and compares with the
// parent at each level it climbs, and a pop loads the root and the last entry, then reads and
// compares the children at each level it descends. One request is handled at a time; the
// next request is taken the cycle after the response is registered. Reset clears the entry
// count and the order mode; the heap memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_heap_priority_queue_macros.svh"
// ----------------------------------------------------------------------------
// Binary heap priority queue
// Min- or max-first heap held in one synchronous memory, sifted by a small
// sequencer that reads, compares and writes back one level at a time.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue
   import bhpq_pkg::*;
#(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic             csr_wdata,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_kind,
   input  wire logic [KEY_W-1:0] req_key,
   input  wire logic [PAY_W-1:0] req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [KEY_W-1:0]      rsp_out_key,
   output logic [PAY_W-1:0]      rsp_out_payload,
   output logic [OCC_W-1:0]      rsp_occupancy
);

   localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CW = $clog2(HEAP_DEPTH + 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_UP_RD   = 3'd1;
   localparam logic [2:0] ST_UP_CMP  = 3'd2;
   localparam logic [2:0] ST_DN_LOAD = 3'd3;
   localparam logic [2:0] ST_DN_RD   = 3'd4;
   localparam logic [2:0] ST_DN_CMP  = 3'd5;
   localparam logic [2:0] ST_DONE    = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    pos_ff, pos_in;
   entry_type        entry_ff, entry_in;
   entry_type        top_ff, top_in;
   logic [1:0]       status_ff, status_in;
   logic             max_first_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff;
   entry_type        rsp_entry_ff;
   logic [OCC_W-1:0] rsp_occ_ff;
   logic             rsp_load;

   entry_type        heap_mem [HEAP_DEPTH];
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   entry_type        mem_wdata;
   logic [AW-1:0]    rd_addr_a, rd_addr_b;
   entry_type        rd_a_ff, rd_b_ff;

   logic [AW-1:0]    parent_addr;
   logic [AW:0]      left_idx, right_idx, count_ext;
   logic             left_absent, right_absent;
   logic             pick_left;
   entry_type        pick_entry;
   logic [AW:0]      pick_idx;
   logic             req_fire;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;

   assign parent_addr  = (pos_ff - AW'(1)) >> 1;
   assign left_idx     = {pos_ff, 1'b1};
   assign right_idx    = {pos_ff, 1'b0} + (AW+1)'(2);
   assign count_ext    = (AW+1)'(count_ff);
   assign left_absent  = (left_idx >= count_ext);
   assign right_absent = (right_idx >= count_ext);
   assign pick_left    = right_absent ||
                         comes_before(max_first_ff, rd_a_ff.key, rd_b_ff.key);
   assign pick_entry   = pick_left ? rd_a_ff : rd_b_ff;
   assign pick_idx     = pick_left ? left_idx : right_idx;

   // read address selection
   always_comb begin
      rd_addr_a = '0;
      rd_addr_b = AW'(count_ff - 1'b1);
      case (state_ff)
         ST_UP_RD: begin
            rd_addr_a = parent_addr;
         end
         ST_DN_RD: begin
            rd_addr_a = left_idx[AW-1:0];
            rd_addr_b = right_idx[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      entry_in  = entry_ff;
      top_in    = top_ff;
      status_in = status_ff;
      mem_we    = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = entry_ff;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               top_in    = '0;
               status_in = STATUS_OK;
               if (req_kind == KIND_PUSH) begin
                  if (count_ff == CW'(HEAP_DEPTH)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_DONE;
                  end else begin
                     entry_in = '{key: req_key, payload: req_payload};
                     pos_in   = AW'(count_ff);
                     count_in = count_ff + 1'b1;
                     state_in = ST_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = ST_DONE;
                  end else begin
                     count_in = count_ff - 1'b1;
                     state_in = ST_DN_LOAD;
                  end
               end
            end
         end
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            mem_we = 1'b1;
            if (comes_before(max_first_ff, entry_ff.key, rd_a_ff.key)) begin
               // pull the parent down and climb
               mem_wdata = rd_a_ff;
               pos_in    = parent_addr;
               state_in  = ST_UP_RD;
            end else begin
               state_in  = ST_DONE;
            end
         end
         ST_DN_LOAD: begin
            top_in   = rd_a_ff;
            entry_in = rd_b_ff;
            pos_in   = '0;
            state_in = ST_DN_RD;
         end
         ST_DN_RD: begin
            if (left_absent) begin
               mem_we   = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            mem_we = 1'b1;
            if (comes_before(max_first_ff, pick_entry.key, entry_ff.key)) begin
               // lift the chosen child and descend
               mem_wdata = pick_entry;
               pos_in    = pick_idx[AW-1:0];
               state_in  = ST_DN_RD;
            end else begin
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         max_first_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            max_first_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      entry_ff  <= entry_in;
      top_ff    <= top_in;
      status_ff <= status_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_entry_ff  <= top_ff;
         rsp_occ_ff    <= OCC_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= heap_mem[rd_addr_a];
      rd_b_ff <= heap_mem[rd_addr_b];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_key     = rsp_entry_ff.key;
   assign rsp_out_payload = rsp_entry_ff.payload;
   assign rsp_occupancy   = rsp_occ_ff;

   `BHPQ_ASSERT_NOW(a_count_range, 1'b1, count_ff <= CW'(HEAP_DEPTH), "entry count above depth")
   `BHPQ_ASSERT_NEXT(a_accept_busy, req_fire, state_ff != ST_IDLE, "accepted request left idle")
   `BHPQ_ASSERT_NEXT(a_pop_count, req_fire && req_kind == KIND_POP && count_ff != '0, count_ff == $past(count_ff) - 1'b1, "pop did not drop count")
   `BHPQ_ASSERT_NOW(a_refused_zero, rsp_valid && rsp_status != STATUS_OK, rsp_out_key == '0 && rsp_out_payload == '0, "refused request carries data")
   `BHPQ_ASSERT_NOW(a_write_busy, mem_we, state_ff != ST_IDLE && state_ff != ST_DONE, "heap write outside sift")

endmodule
`default_nettype wire
